[rtl/aifp_pkg.sv]
// Shared types and constants of the ASCII integer field parser.
`timescale 1ns / 1ps

package aifp_pkg;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_SKIP       = 4'b0001,
        PH_PREFIX     = 4'b0010,
        PH_AFTER_ZERO = 4'b0100,
        PH_DIGITS     = 4'b1000
    } phase_t;

    // Base selection codes.
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_DEC  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    // Result size codes; any other code keeps all 64 bits.
    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_32 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_CONVERTED = 2'd0;
    localparam logic [1:0] ST_MATCH_ERR = 2'd1;
    localparam logic [1:0] ST_NO_INPUT  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_BASE_SELECT  = 2'd0;
    localparam logic [1:0] REG_POINTER_MODE = 2'd1;
    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd2;
    localparam logic [1:0] REG_RESULT_SIZE  = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NBSP  = 8'hA0;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_X  = 8'h78;

endpackage

[rtl/ascii_integer_field_parser.sv]
// Top level of the ASCII integer field parser: character stream in, parsed integers out.
`timescale 1ns / 1ps

// The parser takes one character per transfer on the s_ channel and converts one
// integer field at a time, in the manner of a scanf integer conversion. Leading blanks
// (HT through CR, space and 0xA0) are skipped, then an optional sign is taken, and in
// auto base mode a leading "0" selects octal and "0x" or "0X" selects hexadecimal.
// Digits are gathered into an accumulator of VALUE_WIDTH bits that wraps on overflow.
// The field ends at the first character that does not belong to it, at an end of input
// marker, or when the field width is used up; one result transfer then goes out on the
// m_ channel with the value (negated for a minus sign, then cut to 16, 32 or 64 bits),
// a status, and a flag that tells whether the terminating character was consumed. When
// that flag is 0, the character must be presented again as the first one of the next
// field. The whole step for a character (a shift-and-add by the radix, the width count
// and the phase decision) is done by one layer of logic between the state registers,
// so a character can be accepted in every cycle that s_ready allows, and a result appears
// on the m_ channel in the cycle after the character that ends the field. The result
// sits in an output register, and the parser keeps taking characters while the sink
// takes that result in the same cycle. base_select and field_width are sampled at the
// first non-blank character of a field; pointer_mode and result_size are used live.
// Configuration writes are taken in every cycle and are meant for times when no field
// is in progress or a partial field may keep its sampled settings. There is no clearing
// pass after reset.
module ascii_integer_field_parser #(
    parameter int VALUE_WIDTH     = 64,
    parameter int MAX_FIELD_WIDTH = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Character input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_input,

    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [1:0]  m_status,
    output logic        m_char_consumed
);

    // Width of the count of field slots left; it must hold MAX_FIELD_WIDTH itself.
    localparam int WLW = $clog2(MAX_FIELD_WIDTH + 1);

    // Configuration registers.
    logic [1:0]  base_select_reg;
    logic        pointer_mode_reg;
    logic [15:0] field_width_reg;
    logic [1:0]  result_size_reg;

    // Field state.
    aifp_pkg::phase_t         phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0]   acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [WLW-1:0]           width_left_reg, width_left_next;
    logic [1:0]               base_reg, base_next;
    logic                     digit_seen_reg, digit_seen_next;
    logic                     space_used_reg, space_used_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_value_reg, m_value_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_consumed_reg, m_consumed_next;

    // Step decode.
    logic                   s_fire;
    logic                   emit;
    logic [1:0]             emit_status;
    logic                   emit_consumed;
    logic [WLW-1:0]         width_limit;
    logic [31:0]            field_width_ext;
    logic                   is_blank;
    logic                   is_sign;
    logic                   is_zero;
    logic                   is_x;
    logic [3:0]             digit;
    logic                   digit_ok;
    logic [VALUE_WIDTH-1:0] acc_scaled;
    logic [VALUE_WIDTH-1:0] acc_final;
    logic [VALUE_WIDTH-1:0] value_signed;
    logic [63:0]            value_sized;

    assign cfg_ready = 1'b1;

    // A new character can enter whenever the output register is empty or is being
    // drained in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_value         = m_value_reg;
    assign m_status        = m_status_reg;
    assign m_char_consumed = m_consumed_reg;

    // A field width of zero, or one beyond the supported maximum, means the maximum.
    assign field_width_ext = 32'(field_width_reg);
    always_comb begin
        if (field_width_ext == 32'd0 || field_width_ext > 32'(MAX_FIELD_WIDTH)) begin
            width_limit = WLW'(MAX_FIELD_WIDTH);
        end else begin
            width_limit = WLW'(field_width_ext);
        end
    end

    // Character classes.
    assign is_blank = (s_char_code >= aifp_pkg::CH_HT && s_char_code <= aifp_pkg::CH_CR)
                      || s_char_code == aifp_pkg::CH_SPACE
                      || s_char_code == aifp_pkg::CH_NBSP;
    assign is_sign  = s_char_code == aifp_pkg::CH_PLUS || s_char_code == aifp_pkg::CH_MINUS;
    assign is_zero  = s_char_code == aifp_pkg::CH_ZERO;
    assign is_x     = s_char_code == aifp_pkg::CH_LC_X || s_char_code == aifp_pkg::CH_UC_X;

    // Combinational step over one character. The flow follows the field grammar:
    // blanks, then sign, then prefix, then digits; one character may pass several of
    // these gates in the same step when an earlier one does not claim it.
    always_comb begin
        logic go_prefix;
        logic go_digit;
        logic hex_letter;

        go_prefix     = 1'b0;
        go_digit      = 1'b0;
        hex_letter    = 1'b0;
        emit          = 1'b0;
        emit_status   = aifp_pkg::ST_CONVERTED;
        emit_consumed = 1'b0;
        digit         = 4'd0;
        digit_ok      = 1'b0;
        acc_scaled    = acc_reg;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        width_left_next = width_left_reg;
        base_next       = base_reg;
        digit_seen_next = digit_seen_reg;
        space_used_next = space_used_reg;

        if (s_end_of_input) begin
            emit = 1'b1;
            if (phase_reg != aifp_pkg::PH_SKIP && digit_seen_reg) begin
                emit_status = aifp_pkg::ST_CONVERTED;
            end else begin
                emit_status = aifp_pkg::ST_NO_INPUT;
            end
        end else begin
            unique case (phase_reg)
                aifp_pkg::PH_SKIP: begin
                    if (!is_blank) begin
                        width_left_next = width_limit;
                        base_next = pointer_mode_reg ? aifp_pkg::BASE_HEX : base_select_reg;
                        if (is_sign) begin
                            neg_next = (s_char_code == aifp_pkg::CH_MINUS);
                            if (width_limit <= WLW'(1)) begin
                                emit          = 1'b1;
                                emit_status   = aifp_pkg::ST_MATCH_ERR;
                                emit_consumed = 1'b1;
                            end else begin
                                width_left_next = width_limit - WLW'(1);
                                phase_next      = aifp_pkg::PH_PREFIX;
                            end
                        end else begin
                            go_prefix = 1'b1;
                        end
                    end
                end
                aifp_pkg::PH_PREFIX: begin
                    go_prefix = 1'b1;
                end
                aifp_pkg::PH_AFTER_ZERO: begin
                    if (is_x) begin
                        base_next       = aifp_pkg::BASE_HEX;
                        digit_seen_next = 1'b0;
                        if (pointer_mode_reg) begin
                            space_used_next = 1'b1;
                        end
                        if (width_left_reg <= WLW'(1)) begin
                            emit          = 1'b1;
                            emit_status   = aifp_pkg::ST_MATCH_ERR;
                            emit_consumed = 1'b1;
                        end else begin
                            width_left_next = width_left_reg - WLW'(1);
                            phase_next      = aifp_pkg::PH_DIGITS;
                        end
                    end else begin
                        if (base_reg == aifp_pkg::BASE_AUTO) begin
                            base_next = aifp_pkg::BASE_OCT;
                        end
                        phase_next = aifp_pkg::PH_DIGITS;
                        go_digit   = 1'b1;
                    end
                end
                aifp_pkg::PH_DIGITS: begin
                    go_digit = 1'b1;
                end
                default: begin
                    phase_next = aifp_pkg::PH_SKIP;
                end
            endcase

            // Prefix: a lone zero in auto or pointer mode may open "0x".
            if (go_prefix) begin
                if ((base_next == aifp_pkg::BASE_AUTO || pointer_mode_reg) && is_zero) begin
                    digit_seen_next = 1'b1;
                    acc_next        = '0;
                    if (width_left_next <= WLW'(1)) begin
                        emit          = 1'b1;
                        emit_status   = aifp_pkg::ST_CONVERTED;
                        emit_consumed = 1'b1;
                    end else begin
                        width_left_next = width_left_next - WLW'(1);
                        phase_next      = aifp_pkg::PH_AFTER_ZERO;
                    end
                end else begin
                    if (pointer_mode_reg) begin
                        base_next = aifp_pkg::BASE_HEX;
                    end else if (base_next == aifp_pkg::BASE_AUTO) begin
                        base_next = aifp_pkg::BASE_DEC;
                    end
                    phase_next = aifp_pkg::PH_DIGITS;
                    go_digit   = 1'b1;
                end
            end

            // Digits of the active base; octal rejects 8 and 9 before they touch the value.
            if (go_digit) begin
                hex_letter = base_next == aifp_pkg::BASE_HEX;
                if (s_char_code >= aifp_pkg::CH_ZERO && s_char_code <= aifp_pkg::CH_NINE) begin
                    digit    = 4'(s_char_code - aifp_pkg::CH_ZERO);
                    digit_ok = !(base_next == aifp_pkg::BASE_OCT && digit[3]);
                end else if (hex_letter && s_char_code >= aifp_pkg::CH_UC_A
                             && s_char_code <= aifp_pkg::CH_UC_F) begin
                    digit    = 4'(s_char_code - aifp_pkg::CH_UC_A + 8'd10);
                    digit_ok = 1'b1;
                end else if (hex_letter && s_char_code >= aifp_pkg::CH_LC_A
                             && s_char_code <= aifp_pkg::CH_LC_F) begin
                    digit    = 4'(s_char_code - aifp_pkg::CH_LC_A + 8'd10);
                    digit_ok = 1'b1;
                end

                // Multiply by the radix as shifts: 8x, 16x, or 8x + 2x.
                unique case (base_next)
                    aifp_pkg::BASE_OCT: acc_scaled = acc_next << 3;
                    aifp_pkg::BASE_HEX: acc_scaled = acc_next << 4;
                    aifp_pkg::BASE_DEC,
                    aifp_pkg::BASE_AUTO: acc_scaled = (acc_next << 3) + (acc_next << 1);
                endcase

                if (digit_ok || (pointer_mode_reg && s_char_code == aifp_pkg::CH_SPACE
                                 && !space_used_next)) begin
                    if (digit_ok) begin
                        acc_next        = acc_scaled + VALUE_WIDTH'(digit);
                        digit_seen_next = 1'b1;
                    end else begin
                        space_used_next = 1'b1;
                    end
                    if (width_left_next <= WLW'(1)) begin
                        emit          = 1'b1;
                        emit_status   = digit_seen_next ? aifp_pkg::ST_CONVERTED
                                                        : aifp_pkg::ST_MATCH_ERR;
                        emit_consumed = 1'b1;
                    end else begin
                        width_left_next = width_left_next - WLW'(1);
                    end
                end else begin
                    emit          = 1'b1;
                    emit_status   = digit_seen_next ? aifp_pkg::ST_CONVERTED
                                                    : aifp_pkg::ST_MATCH_ERR;
                    emit_consumed = 1'b0;
                end
            end
        end

        // Closing a field returns the state to the start of the next one.
        if (emit) begin
            phase_next      = aifp_pkg::PH_SKIP;
            acc_next        = '0;
            neg_next        = 1'b0;
            digit_seen_next = 1'b0;
            space_used_next = 1'b0;
            width_left_next = width_limit;
            base_next       = base_select_reg;
        end
    end

    // The value at emission is the accumulator after this step's digit, if any.
    assign acc_final = digit_ok ? acc_scaled + VALUE_WIDTH'(digit) : acc_reg;

    // Result value: negate, then cut to the selected size. Only a converted field
    // carries a value.
    assign value_signed = neg_reg ? (VALUE_WIDTH'(0) - acc_final) : acc_final;

    always_comb begin
        value_sized = 64'(value_signed);
        unique case (result_size_reg)
            aifp_pkg::SIZE_16: value_sized = {48'd0, value_sized[15:0]};
            aifp_pkg::SIZE_32: value_sized = {32'd0, value_sized[31:0]};
            aifp_pkg::SIZE_64: value_sized = value_sized;
            default:           value_sized = value_sized;
        endcase
    end

    // Output register next values.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        m_consumed_next = m_consumed_reg;
        if (s_fire) begin
            m_valid_next = emit;
            if (emit) begin
                m_value_next    = (emit_status == aifp_pkg::ST_CONVERTED) ? value_sized : 64'd0;
                m_status_next   = emit_status;
                m_consumed_next = emit_consumed;
            end
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_select_reg  <= aifp_pkg::BASE_DEC;
            pointer_mode_reg <= 1'b0;
            field_width_reg  <= 16'd0;
            result_size_reg  <= aifp_pkg::SIZE_32;
            phase_reg        <= aifp_pkg::PH_SKIP;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            width_left_reg   <= '0;
            base_reg         <= aifp_pkg::BASE_DEC;
            digit_seen_reg   <= 1'b0;
            space_used_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    aifp_pkg::REG_BASE_SELECT:  base_select_reg  <= cfg_data[1:0];
                    aifp_pkg::REG_POINTER_MODE: pointer_mode_reg <= cfg_data[0];
                    aifp_pkg::REG_FIELD_WIDTH:  field_width_reg  <= cfg_data;
                    aifp_pkg::REG_RESULT_SIZE:  result_size_reg  <= cfg_data[1:0];
                endcase
            end
            if (s_fire) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                neg_reg        <= neg_next;
                width_left_reg <= width_left_next;
                base_reg       <= base_next;
                digit_seen_reg <= digit_seen_next;
                space_used_reg <= space_used_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        m_consumed_reg <= m_consumed_next;
    end

endmodule
